>>> rtl/k_way_sorted_merge_macros.svh
// Assertion macros shared by the merge RTL.
// Needs nothing; take it by `include where a module asserts.
`ifndef K_WAY_SORTED_MERGE_MACROS_SVH
`define K_WAY_SORTED_MERGE_MACROS_SVH

// Same-cycle implication, gated off while reset is high.
`define KWM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, gated off while reset is high.
`define KWM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/kwm_pkg.sv
// Types and constants of the k-way sorted merge.
// No dependencies; used by the interfaces, the CSR block and the top level.
package kwm_pkg;

   localparam int DEF_LANES  = 16;
   localparam int LANE_W     = 4;
   localparam int VALUE_W    = 32;
   localparam int CFG_W      = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CFG_W-1:0] LANES_IN_USE_RST = 5'd16;
   // word index of the lanes_in_use register (paddr bit 2)
   localparam logic [0:0]       CSR_IDX_LANES    = 1'b0;

   typedef enum logic [1:0] {
      KIND_ELEMENT = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_REJECT  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_PUSH
   } state_type;

endpackage

>>> rtl/kwm_req_if.sv
// Input beat channel of the merge: valid/ready plus lane, value, exhausted.
// Depends on kwm_pkg.
interface kwm_req_if;
   logic                              valid;
   logic                              ready;
   logic [kwm_pkg::LANE_W-1:0]        lane;
   logic signed [kwm_pkg::VALUE_W-1:0] value;
   logic                              exhausted;

   modport source (output valid, lane, value, exhausted, input ready);
   modport sink   (input valid, lane, value, exhausted, output ready);
endinterface

>>> rtl/kwm_rsp_if.sv
// Result beat channel of the merge: valid/ready plus kind, merged_value, source_lane.
// Depends on kwm_pkg.
interface kwm_rsp_if;
   logic                              valid;
   logic                              ready;
   kwm_pkg::kind_type                 kind;
   logic signed [kwm_pkg::VALUE_W-1:0] merged_value;
   logic [kwm_pkg::LANE_W-1:0]        source_lane;

   modport source (output valid, kind, merged_value, source_lane, input ready);
   modport sink   (input valid, kind, merged_value, source_lane, output ready);
endinterface

>>> rtl/kwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kwm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/kwm_csr.sv
// APB-style register block holding lanes_in_use.
// Depends on kwm_pkg.
module kwm_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [kwm_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [kwm_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [kwm_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready,
   output logic [kwm_pkg::CFG_W-1:0]          lanes_in_use
);

   logic [kwm_pkg::CFG_W-1:0] lanes_ff;
   logic [kwm_pkg::CFG_W-1:0] lanes_in;
   logic                      hit;

   assign hit    = (paddr[kwm_pkg::CSR_ADDR_W-1:2] == kwm_pkg::CSR_IDX_LANES);
   assign pready = 1'b1;

   always_comb begin
      lanes_in = lanes_ff;
      if (psel && penable && pwrite && hit) begin
         lanes_in = pwdata[kwm_pkg::CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lanes_ff <= kwm_pkg::LANES_IN_USE_RST;
      end else begin
         lanes_ff <= lanes_in;
      end
   end

   assign prdata       = hit ? kwm_pkg::CSR_DATA_W'(lanes_ff) : '0;
   assign lanes_in_use = lanes_ff;

endmodule

>>> rtl/k_way_sorted_merge.sv
// k_way_sorted_merge: min-selection merge of up to LANES ascending streams.
// Element beat: result set by one shared comparator scanning the head RAM one lane per
//   cycle, then DRAIN, DECIDE and PUSH; ready again in the same cycle as the result.
// Rejected beat: result via PUSH and the output register. Fill beat without result: stays ready.
// Synchronous active-high reset empties all lanes and restarts filling; no
//   clearing pass, head RAM contents are don't-care until written.
`include "k_way_sorted_merge_macros.svh"

module k_way_sorted_merge #(
   parameter int LANES = kwm_pkg::DEF_LANES
) (
   input  logic                           clock,
   input  logic                           reset,
   kwm_req_if.sink                        req_bus,
   kwm_rsp_if.source                      rsp_bus,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [kwm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [kwm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [kwm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   // index into per-lane storage, count up to LANES, common width for lane compares
   localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int CNT_W = $clog2(LANES + 1);
   localparam int EXT_W = (IDX_W > kwm_pkg::LANE_W) ? IDX_W : kwm_pkg::LANE_W;

   // ------------------------------------------------------------------
   // Config
   // ------------------------------------------------------------------
   logic [kwm_pkg::CFG_W-1:0] lanes_cfg;
   logic [CNT_W-1:0]          used;
   logic [LANES-1:0]          used_mask;

   kwm_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (csr_psel),
      .penable      (csr_penable),
      .pwrite       (csr_pwrite),
      .paddr        (csr_paddr),
      .pwdata       (csr_pwdata),
      .prdata       (csr_prdata),
      .pready       (csr_pready),
      .lanes_in_use (lanes_cfg)
   );

   // zero acts as one lane, anything above LANES saturates
   always_comb begin
      if (lanes_cfg == '0) begin
         used = CNT_W'(1);
      end else if (32'(lanes_cfg) > 32'(LANES)) begin
         used = CNT_W'(LANES);
      end else begin
         used = CNT_W'(lanes_cfg);
      end
      for (int i = 0; i < LANES; i++) begin
         used_mask[i] = (32'(i) < 32'(used));
      end
   end

   // ------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------
   kwm_pkg::state_type state_ff, state_in;

   logic [LANES-1:0]  valid_ff, valid_in;       // head held per lane
   logic [LANES-1:0]  finished_ff, finished_in; // end mark seen per lane
   logic              filling_ff, filling_in;
   logic [IDX_W-1:0]  awaited_ff, awaited_in;

   // scan sequencer
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic              cmp_go_ff, cmp_go_in;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  best_ff, best_in;
   logic signed [kwm_pkg::VALUE_W-1:0] best_val_ff, best_val_in;

   // pending result, waits in PUSH for the output register
   kwm_pkg::kind_type                  res_kind_ff, res_kind_in;
   logic signed [kwm_pkg::VALUE_W-1:0] res_value_ff, res_value_in;
   logic [kwm_pkg::LANE_W-1:0]         res_lane_ff, res_lane_in;

   // output register
   logic                               out_valid_ff, out_valid_in;
   kwm_pkg::kind_type                  out_kind_ff, out_kind_in;
   logic signed [kwm_pkg::VALUE_W-1:0] out_value_ff, out_value_in;
   logic [kwm_pkg::LANE_W-1:0]         out_lane_ff, out_lane_in;

   // ------------------------------------------------------------------
   // Head RAM: written on an accepted element, read by the scan
   // ------------------------------------------------------------------
   logic                         ram_we;
   logic [kwm_pkg::VALUE_W-1:0]  ram_rd_data;
   logic [IDX_W-1:0]             lane_idx;

   kwm_ram #(
      .WIDTH (kwm_pkg::VALUE_W),
      .DEPTH (LANES)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (lane_idx),
      .wr_data (kwm_pkg::VALUE_W'(req_bus.value)),
      .rd_addr (cnt_ff),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------
   // Input decode
   // ------------------------------------------------------------------
   logic [EXT_W-1:0] lane_ext;
   logic [EXT_W-1:0] awaited_ext;
   logic [EXT_W-1:0] best_ext;
   logic [LANES-1:0] lane_onehot;
   logic             accept;
   logic             reject;
   logic             take;
   logic             fill_done;
   logic             less;

   assign lane_ext    = EXT_W'(req_bus.lane);
   assign awaited_ext = EXT_W'(awaited_ff);
   assign best_ext    = EXT_W'(best_ff);
   assign lane_idx    = lane_ext[IDX_W-1:0];
   assign lane_onehot = LANES'(1) << lane_idx;

   assign req_bus.ready = (state_ff == kwm_pkg::ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   // filling: lane out of use or already delivered; merging: not the awaited lane
   assign reject = filling_ff
                   ? ((32'(req_bus.lane) >= 32'(used)) || valid_ff[lane_idx]
                      || finished_ff[lane_idx])
                   : (lane_ext != awaited_ext);
   assign take   = accept && !reject;
   assign ram_we = take && !req_bus.exhausted;

   // every lane in use has a head or an end mark once this beat lands
   assign fill_done = ((used_mask & ~(valid_ff | finished_ff | lane_onehot)) == '0);

   // the one shared comparator: strict less keeps the lowest lane on ties
   assign less = $signed(ram_rd_data) < best_val_ff;

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      finished_in  = finished_ff;
      filling_in   = filling_ff;
      awaited_in   = awaited_ff;
      cnt_in       = cnt_ff;
      cmp_go_in    = 1'b0;
      found_in     = found_ff;
      best_in      = best_ff;
      best_val_in  = best_val_ff;
      res_kind_in  = res_kind_ff;
      res_value_in = res_value_ff;
      res_lane_in  = res_lane_ff;

      // compare stage works on the registered RAM read, in the cycle after it
      if (cmp_go_ff && valid_ff[rd_idx_ff] && (!found_ff || less)) begin
         found_in    = 1'b1;
         best_in     = rd_idx_ff;
         best_val_in = $signed(ram_rd_data);
      end

      unique case (state_ff)
         kwm_pkg::ST_IDLE: begin
            if (accept) begin
               if (reject) begin
                  res_kind_in  = kwm_pkg::KIND_REJECT;
                  res_value_in = '0;
                  res_lane_in  = req_bus.lane;
                  state_in     = kwm_pkg::ST_PUSH;
               end else begin
                  if (req_bus.exhausted) begin
                     finished_in[lane_idx] = 1'b1;
                  end else begin
                     valid_in[lane_idx] = 1'b1;
                  end
                  if (!filling_ff || fill_done) begin
                     filling_in = 1'b0;
                     cnt_in     = '0;
                     found_in   = 1'b0;
                     state_in   = kwm_pkg::ST_SCAN;
                  end
               end
            end
         end
         kwm_pkg::ST_SCAN: begin
            cmp_go_in = 1'b1;
            if (cnt_ff == IDX_W'(LANES - 1)) begin
               state_in = kwm_pkg::ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end
         kwm_pkg::ST_DRAIN: begin
            state_in = kwm_pkg::ST_DECIDE;
         end
         kwm_pkg::ST_DECIDE: begin
            if (found_ff) begin
               valid_in[best_ff] = 1'b0;
               awaited_in        = best_ff;
               res_kind_in       = kwm_pkg::KIND_ELEMENT;
               res_value_in      = best_val_ff;
               res_lane_in       = best_ext[kwm_pkg::LANE_W-1:0];
            end else begin
               // nothing held: merge complete, back to filling
               valid_in     = '0;
               finished_in  = '0;
               filling_in   = 1'b1;
               awaited_in   = '0;
               res_kind_in  = kwm_pkg::KIND_DONE;
               res_value_in = '0;
               res_lane_in  = '0;
            end
            state_in = kwm_pkg::ST_PUSH;
         end
         kwm_pkg::ST_PUSH: begin
            if (!out_valid_ff || rsp_bus.ready) begin
               state_in = kwm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kwm_pkg::ST_IDLE;
         end
      endcase
   end

   // output register: loads from PUSH once the slot is free
   always_comb begin
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_value_in = out_value_ff;
      out_lane_in  = out_lane_ff;
      if (out_valid_ff && rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
      if (state_ff == kwm_pkg::ST_PUSH && (!out_valid_ff || rsp_bus.ready)) begin
         out_valid_in = 1'b1;
         out_kind_in  = res_kind_ff;
         out_value_in = res_value_ff;
         out_lane_in  = res_lane_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kwm_pkg::ST_IDLE;
         valid_ff     <= '0;
         finished_ff  <= '0;
         filling_ff   <= 1'b1;
         awaited_ff   <= '0;
         cnt_ff       <= '0;
         cmp_go_ff    <= 1'b0;
         found_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         finished_ff  <= finished_in;
         filling_ff   <= filling_in;
         awaited_ff   <= awaited_in;
         cnt_ff       <= cnt_in;
         cmp_go_ff    <= cmp_go_in;
         found_ff     <= found_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      rd_idx_ff    <= cnt_ff;
      best_ff      <= best_in;
      best_val_ff  <= best_val_in;
      res_kind_ff  <= res_kind_in;
      res_value_ff <= res_value_in;
      res_lane_ff  <= res_lane_in;
      out_kind_ff  <= out_kind_in;
      out_value_ff <= out_value_in;
      out_lane_ff  <= out_lane_in;
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.kind         = out_kind_ff;
   assign rsp_bus.merged_value = out_value_ff;
   assign rsp_bus.source_lane  = out_lane_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `KWM_ASSERT_IMP(a_scan_in_merge, clock, reset, state_ff == kwm_pkg::ST_SCAN,
      !filling_ff, "scan started while still filling")
   `KWM_ASSERT_IMP(a_best_held, clock, reset, state_ff == kwm_pkg::ST_DECIDE && found_ff,
      valid_ff[best_ff], "selected lane holds no head")
   `KWM_ASSERT_IMP(a_head_or_end, clock, reset, 1'b1, (valid_ff & finished_ff) == '0,
      "lane holds a head after its end mark")
   `KWM_ASSERT_NXT(a_done_clears, clock, reset, state_ff == kwm_pkg::ST_DECIDE && !found_ff,
      filling_ff && valid_ff == '0 && finished_ff == '0, "completion left state behind")

endmodule

>>> tb/kwm_merge_checker.sv
`timescale 1ns / 1ps
// Scoreboard for k_way_sorted_merge: snoops both beat channels and the CSR port.
// It predicts each result beat and compares it with what the block returns.
// Depends on kwm_pkg and the kwm_req_if / kwm_rsp_if interfaces.
module kwm_merge_checker #(
   parameter int LANES = kwm_pkg::DEF_LANES
) (
   input  logic                           clock,
   input  logic                           reset,
   kwm_req_if                             req_bus,
   kwm_rsp_if                             rsp_bus,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [kwm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [kwm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic [kwm_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  logic                           csr_pready,
   output int                             failures,
   output int                             pending
);

   typedef struct {
      kwm_pkg::kind_type                  kind;
      logic signed [kwm_pkg::VALUE_W-1:0] merged_value;
      logic [kwm_pkg::LANE_W-1:0]         source_lane;
   } merge_beat_type;

   merge_beat_type                     merge_q[$];
   logic [kwm_pkg::CFG_W-1:0]          lanes_cfg;
   logic signed [kwm_pkg::VALUE_W-1:0] head_val[LANES];
   logic [LANES-1:0]                   head_held;
   logic [LANES-1:0]                   lane_done;
   logic                               filling;
   logic [kwm_pkg::LANE_W-1:0]         await_lane;

   initial begin
      failures = 0;
      pending  = 0;
   end

   function automatic void log_failure(input string msg);
      failures++;
      if (failures <= 10) $display("%t %s", $realtime, msg);
   endfunction

   // One accepted input beat: update the merge state, queue the result it causes.
   task automatic predict_merge(input logic [kwm_pkg::LANE_W-1:0] lane,
                                input logic signed [kwm_pkg::VALUE_W-1:0] value,
                                input logic exh);
      int  used;
      int  i;
      int  best;
      bit  reject;
      bit  all_in;
      bit  found;
      used = (lanes_cfg == '0) ? 1 : ((int'(lanes_cfg) > LANES) ? LANES : int'(lanes_cfg));
      if (filling) reject = (int'(lane) >= used) || head_held[lane] || lane_done[lane];
      else reject = (lane != await_lane);
      if (reject) begin
         merge_q.push_back('{kind: kwm_pkg::KIND_REJECT, merged_value: '0,
                             source_lane: lane});
         return;
      end
      if (exh) begin
         lane_done[lane] = 1'b1;
      end else begin
         head_val[lane]  = value;
         head_held[lane] = 1'b1;
      end
      if (filling) begin
         all_in = 1'b1;
         for (i = 0; i < used; i++) begin
            if (!head_held[i] && !lane_done[i]) all_in = 1'b0;
         end
         if (!all_in) return;
         filling = 1'b0;
      end
      // smallest held head over every lane, lowest lane wins a tie
      found = 1'b0;
      best  = 0;
      for (i = 0; i < LANES; i++) begin
         if (head_held[i] && (!found || head_val[i] < head_val[best])) begin
            best  = i;
            found = 1'b1;
         end
      end
      if (!found) begin
         head_held  = '0;
         lane_done  = '0;
         filling    = 1'b1;
         await_lane = '0;
         merge_q.push_back('{kind: kwm_pkg::KIND_DONE, merged_value: '0, source_lane: '0});
      end else begin
         head_held[best] = 1'b0;
         await_lane      = best[kwm_pkg::LANE_W-1:0];
         merge_q.push_back('{kind: kwm_pkg::KIND_ELEMENT, merged_value: head_val[best],
                             source_lane: best[kwm_pkg::LANE_W-1:0]});
      end
   endtask

   always @(posedge clock) begin
      merge_beat_type exp;
      if (reset) begin
         lanes_cfg  = kwm_pkg::LANES_IN_USE_RST;
         head_held  = '0;
         lane_done  = '0;
         filling    = 1'b1;
         await_lane = '0;
         merge_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[kwm_pkg::CSR_ADDR_W-1:2] == kwm_pkg::CSR_IDX_LANES)
                  lanes_cfg = csr_pwdata[kwm_pkg::CFG_W-1:0];
            end else if (csr_prdata[kwm_pkg::CFG_W-1:0] !== lanes_cfg) begin
               log_failure($sformatf("lanes_in_use read back %0d, expected %0d",
                                     csr_prdata[kwm_pkg::CFG_W-1:0], lanes_cfg));
            end
         end
         if (req_bus.valid && req_bus.ready)
            predict_merge(req_bus.lane, req_bus.value, req_bus.exhausted);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (merge_q.size() == 0) begin
               log_failure($sformatf("unexpected result beat kind=%0d value=%0d lane=%0d",
                                     rsp_bus.kind, rsp_bus.merged_value,
                                     rsp_bus.source_lane));
            end else begin
               exp = merge_q.pop_front();
               if (rsp_bus.kind !== exp.kind || rsp_bus.merged_value !== exp.merged_value ||
                   rsp_bus.source_lane !== exp.source_lane)
                  log_failure($sformatf(
                     "result mismatch: expected kind=%0d value=%0d lane=%0d, got %0d %0d %0d",
                     exp.kind, exp.merged_value, exp.source_lane, rsp_bus.kind,
                     rsp_bus.merged_value, rsp_bus.source_lane));
            end
         end
      end
      pending = merge_q.size();
   end

endmodule

>>> tb/tb_k_way_sorted_merge.sv
`timescale 1ns / 1ps
// Top of the k_way_sorted_merge testbench: clock, reset, beat and CSR stimulus, verdict.
// Depends on kwm_pkg, the beat interfaces, the block and kwm_merge_checker.
module tb_k_way_sorted_merge;

   localparam int CLK_HALF        = 5;
   localparam int RESET_CYCLES    = 10;
   localparam int RANDOM_ITEMS    = 500;
   localparam int RSP_HOLD_CYCLES = 300;   // long receiver hold-off, fills the block
   localparam int DRAIN_CYCLES    = kwm_pkg::DEF_LANES + 8;  // one full scan plus margin
   localparam int WATCHDOG_LIMIT  = 4000;  // quiet cycles, well over the hold-off
   localparam int NOISE_PCT       = 8;
   localparam int VAL_MIN         = int'(32'h8000_0000);
   localparam int VAL_MAX         = 32'h7FFF_FFFF;
   localparam int EDGE_VALS[7]    = '{VAL_MIN, VAL_MIN + 1, -1, 0, 1, VAL_MAX - 1, VAL_MAX};
   localparam logic [kwm_pkg::CSR_ADDR_W-1:0] LANES_REG_ADDR = {kwm_pkg::CSR_IDX_LANES, 2'b00};
   // lane-count settings walked through by the random part; 0, 17 and 31 are out of range
   localparam int CFG_PLAN[10]    = '{16, 5, 1, 0, 31, 9, 2, 17, 12, 3};

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [kwm_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [kwm_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [kwm_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;
   int                             failures;
   int                             pending;

   kwm_req_if req_bus();
   kwm_rsp_if rsp_bus();

   k_way_sorted_merge u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   kwm_merge_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .failures    (failures),
      .pending     (pending)
   );

   // Stimulus-side bookkeeping. The sender only counts how many result beats its
   // own beats must cause; it learns which lane to refill from the result channel.
   int                         send_idle_pct;
   int                         rsp_idle_pct;
   bit                         hold_rsp;        // request for one long receiver hold-off
   bit                         pressure_due;
   int                         items_sent;
   int                         results_due;
   int                         rsp_beats;
   int                         jobs_done;
   int                         settings_used;
   kwm_pkg::kind_type          last_kind;       // last non-reject result: element or done
   logic [kwm_pkg::LANE_W-1:0] last_lane;
   logic [kwm_pkg::CFG_W-1:0]  lane_count;      // value last written to lanes_in_use
   int                         lane_stream[kwm_pkg::DEF_LANES][$];

   always #CLK_HALF clock = ~clock;

   // Result beats as seen by the sender; rejects do not steer the merge.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_beats <= rsp_beats + 1;
         if (rsp_bus.kind != kwm_pkg::KIND_REJECT) begin
            last_kind <= rsp_bus.kind;
            last_lane <= rsp_bus.source_lane;
         end
      end
   end

   // Receiver: random ready, or one long hold-off on request, counted here.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Watchdog: ends the run when no beat and no CSR access moves for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || csr_psel)
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: nothing moved for %0d cycles, %0d results still expected",
               WATCHDOG_LIMIT, pending);
      $display("RESULT: ERROR");
      $finish;
   end

   // Offer one input beat after a random gap and hold it until accepted.
   // Entered and left at a falling edge; valid stays high for a following beat.
   task automatic send_beat(input logic [kwm_pkg::LANE_W-1:0] lane,
                            input logic [kwm_pkg::VALUE_W-1:0] value,
                            input logic exh, input int yields);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.lane      <= lane;
      req_bus.value     <= value;
      req_bus.exhausted <= exh;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      items_sent++;
      results_due += yields;
   endtask

   // Stop offering and wait until every result owed by the sent beats is back.
   task automatic await_results();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (rsp_beats < results_due) @(negedge clock);
   endtask

   // Idle the block, then write lanes_in_use (junk in the upper bits) and read it back.
   task automatic set_lane_count(input logic [kwm_pkg::CFG_W-1:0] count);
      logic [kwm_pkg::CSR_DATA_W-1:0] word;
      await_results();
      // a fill beat leaves no result; let any scan still running finish
      repeat (DRAIN_CYCLES) @(negedge clock);
      word                     = $urandom;
      word[kwm_pkg::CFG_W-1:0] = count;
      csr_psel        <= 1'b1;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b1;
      csr_paddr       <= LANES_REG_ADDR;
      csr_pwdata      <= word;
      @(negedge clock);
      csr_penable     <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      @(negedge clock);
      csr_penable     <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      lane_count       = count;
      settings_used++;
   endtask

   // One whole merge with random streams: fill every lane in use in random order,
   // then refill whichever lane the block emitted from until it reports done.
   // Wrong-lane beats are mixed in as noise; a few jobs get unsorted streams.
   task automatic run_merge();
      int                         used;
      int                         max_len;
      int                         mode;
      int                         i;
      int                         j;
      int                         k;
      int                         tmp;
      int                         steps;
      int                         v;
      bit                         sorted;
      int                         order[kwm_pkg::DEF_LANES];
      logic [kwm_pkg::LANE_W-1:0] l;
      used    = (lane_count == '0) ? 1
              : ((int'(lane_count) > kwm_pkg::DEF_LANES) ? kwm_pkg::DEF_LANES
                                                         : int'(lane_count));
      max_len = (used > 8) ? 3 : 6;
      mode    = $urandom_range(0, 9);
      sorted  = (mode != 9);
      for (i = 0; i < kwm_pkg::DEF_LANES; i++) begin
         lane_stream[i].delete();
         order[i] = i;
      end
      for (i = 0; i < used; i++) begin
         repeat ($urandom_range(0, max_len)) begin
            if (mode < 4 || mode == 9) v = $urandom;
            else if (mode < 7) v = int'($urandom_range(0, 8)) - 4;   // many ties
            else v = EDGE_VALS[$urandom_range(0, 6)];
            lane_stream[i].push_back(v);
         end
         if (sorted) lane_stream[i].sort();
      end
      for (i = used - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end

      // fill phase: first head or end mark of each lane in use
      for (k = 0; k < used; k++) begin
         if ($urandom_range(99) < NOISE_PCT) begin
            // lane out of range, or a lane that already delivered
            if (used < kwm_pkg::DEF_LANES && (k == 0 || $urandom_range(0, 1)))
               send_beat(kwm_pkg::LANE_W'($urandom_range(used, kwm_pkg::DEF_LANES - 1)),
                         $urandom, 1'($urandom_range(0, 1)), 1);
            else if (k > 0)
               send_beat(kwm_pkg::LANE_W'(order[$urandom_range(0, k - 1)]), $urandom,
                         1'($urandom_range(0, 1)), 1);
         end
         i = order[k];
         if (lane_stream[i].size() > 0)
            send_beat(kwm_pkg::LANE_W'(i), lane_stream[i].pop_front(), 1'b0,
                      (k == used - 1));
         else
            send_beat(kwm_pkg::LANE_W'(i), $urandom, 1'b1, (k == used - 1));
      end

      // merge phase: each beat from the lane just emitted causes the next emission
      steps = 0;
      while (steps < 400) begin
         await_results();
         if (last_kind == kwm_pkg::KIND_DONE) break;
         l = last_lane;
         if ($urandom_range(99) < NOISE_PCT)
            send_beat(l + kwm_pkg::LANE_W'($urandom_range(1, kwm_pkg::DEF_LANES - 1)),
                      $urandom, 1'($urandom_range(0, 1)), 1);
         if (pressure_due) begin
            // receiver holds off while the sender keeps pushing rejects
            pressure_due = 1'b0;
            hold_rsp     = 1'b1;
            repeat (6)
               send_beat(l + kwm_pkg::LANE_W'($urandom_range(1, kwm_pkg::DEF_LANES - 1)),
                         $urandom, 1'($urandom_range(0, 1)), 1);
         end
         if (lane_stream[l].size() > 0)
            send_beat(l, lane_stream[l].pop_front(), 1'b0, 1);
         else
            send_beat(l, $urandom, 1'b1, 1);
         steps++;
      end
      jobs_done++;
   endtask

   initial begin : stimulus
      int profile;
      int plan_idx;
      int goal;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.lane      = '0;
      req_bus.value     = '0;
      req_bus.exhausted = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      send_idle_pct     = 11;
      rsp_idle_pct      = 45;
      hold_rsp          = 1'b0;
      pressure_due      = 1'b0;
      items_sent        = 0;
      results_due       = 0;
      rsp_beats         = 0;
      jobs_done         = 0;
      settings_used     = 0;
      last_kind         = kwm_pkg::KIND_DONE;
      last_lane         = '0;
      lane_count        = kwm_pkg::LANES_IN_USE_RST;
      plan_idx          = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: three lanes. Lane 2 ends at once, lane 0 = {MIN, 5},
      // lane 1 = {5, MAX}; covers rejects in both phases and a tie on 5.
      set_lane_count(kwm_pkg::CFG_W'(3));
      send_beat(kwm_pkg::LANE_W'(2), $urandom, 1'b1, 0);
      send_beat(kwm_pkg::LANE_W'(3), 32'd0, 1'b0, 1);          // lane not in use
      send_beat(kwm_pkg::LANE_W'(1), 32'd5, 1'b0, 0);
      send_beat(kwm_pkg::LANE_W'(1), 32'd7, 1'b0, 1);          // lane already holds a head
      send_beat(kwm_pkg::LANE_W'(2), 32'd9, 1'b1, 1);          // lane already finished
      send_beat(kwm_pkg::LANE_W'(0), VAL_MIN, 1'b0, 1);        // fill complete, MIN out
      await_results();
      send_beat(kwm_pkg::LANE_W'(15), VAL_MAX, 1'b0, 1);       // not the awaited lane
      send_beat(kwm_pkg::LANE_W'(0), 32'd5, 1'b0, 1);          // tie with lane 1, lane 0 wins
      await_results();
      send_beat(kwm_pkg::LANE_W'(0), $urandom, 1'b1, 1);       // lane 1's 5 follows
      await_results();
      send_beat(kwm_pkg::LANE_W'(1), VAL_MAX, 1'b0, 1);
      await_results();
      send_beat(kwm_pkg::LANE_W'(1), 32'hFFFF_FFFF, 1'b1, 1);  // all lanes ended: done
      await_results();
      // Single lane, then an empty merge that completes on its only beat.
      set_lane_count(kwm_pkg::CFG_W'(1));
      send_beat(kwm_pkg::LANE_W'(0), 32'hFFFF_FFFF, 1'b0, 1);
      await_results();
      send_beat(kwm_pkg::LANE_W'(5), 32'd1, 1'b0, 1);
      send_beat(kwm_pkg::LANE_W'(0), 32'd0, 1'b1, 1);
      await_results();
      send_beat(kwm_pkg::LANE_W'(0), 32'h5555_AAAA, 1'b1, 1);
      await_results();

      // Random merges under three idle profiles, walking the lane-count plan.
      for (profile = 0; profile < 3; profile++) begin
         case (profile)
            0: begin
               send_idle_pct = 11;
               rsp_idle_pct  = 45;
            end
            1: begin
               send_idle_pct = 45;
               rsp_idle_pct  = 11;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
         endcase
         pressure_due = 1'b1;
         goal         = items_sent + RANDOM_ITEMS / 3;
         while (items_sent < goal) begin
            set_lane_count(kwm_pkg::CFG_W'(CFG_PLAN[plan_idx % 10]));
            plan_idx++;
            run_merge();
         end
      end

      // Drain, then give the block one more scan's worth of cycles.
      await_results();
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Ran %0d merges from %0d input beats, %0d result beats checked,",
               jobs_done, items_sent, rsp_beats);
      $display("over %0d lane-count writes incl. 0, 1, 16 and 31; %0d failures",
               settings_used, failures);
      if (failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> k_way_sorted_merge.f
+incdir+rtl
rtl/kwm_pkg.sv
rtl/kwm_req_if.sv
rtl/kwm_rsp_if.sv
rtl/kwm_ram.sv
rtl/kwm_csr.sv
rtl/k_way_sorted_merge.sv
tb/kwm_merge_checker.sv
tb/tb_k_way_sorted_merge.sv
